// ===== design/trpc_pkg.sv =====
package trpc_pkg;

    // Record store geometry.
    localparam int RECORD_DEPTH = 32;
    localparam int REC_AW = (RECORD_DEPTH > 1) ? $clog2(RECORD_DEPTH) : 1;
    localparam int REC_CW = $clog2(RECORD_DEPTH + 1);
    localparam int CODE_W = 4;

    // Command queue between the front and the back.
    localparam int QUEUE_DEPTH = 2;
    localparam int Q_AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int Q_CW = $clog2(QUEUE_DEPTH + 1);

    // Command characters.
    localparam logic [7:0] CHAR_UP_A = 8'h41;
    localparam logic [7:0] CHAR_UP_E = 8'h45;
    localparam logic [7:0] CHAR_UP_F = 8'h46;
    localparam logic [7:0] CHAR_UP_G = 8'h47;
    localparam logic [7:0] CHAR_LO_A = 8'h61;
    localparam logic [7:0] CHAR_LO_E = 8'h65;
    localparam logic [7:0] CHAR_LO_F = 8'h66;
    localparam logic [7:0] CHAR_LO_G = 8'h67;

    // Stored entry codes: 2*joint+reverse for pulses, then close and open.
    localparam logic [CODE_W-1:0] CODE_CLOSE = 4'd10;
    localparam logic [CODE_W-1:0] CODE_OPEN  = 4'd11;
    localparam logic [CODE_W-1:0] CODE_NONE  = 4'd15;

    typedef enum logic [1:0] {
        KIND_NONE  = 2'd0,
        KIND_PULSE = 2'd1,
        KIND_GRIP  = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        OP_MOTION = 2'd0,
        OP_TOGGLE = 2'd1,
        OP_PLAY   = 2'd2,
        OP_OTHER  = 2'd3
    } op_t;

    typedef struct packed {
        op_t               op;
        logic [CODE_W-1:0] code;
    } cmd_t;

    typedef struct packed {
        kind_t      kind;
        logic [2:0] joint;
        logic       reverse;
        logic       grip;
    } action_t;

    typedef struct packed {
        action_t act;
        logic    teach;
        logic    dropped;
        logic    playback;
        logic    last;
    } result_t;

    typedef struct packed {
        logic [REC_CW-1:0] record_count;
        logic              playing;
    } back_status_t;

    function automatic cmd_t decode_cmd(input logic [7:0] b);
        cmd_t       c;
        logic [7:0] d;
        c.op   = OP_OTHER;
        c.code = CODE_NONE;
        d      = 8'h00;
        if (b >= CHAR_UP_A && b <= CHAR_UP_E) begin
            d      = b - CHAR_UP_A;
            c.op   = OP_MOTION;
            c.code = {d[2:0], 1'b0};
        end else if (b >= CHAR_LO_A && b <= CHAR_LO_E) begin
            d      = b - CHAR_LO_A;
            c.op   = OP_MOTION;
            c.code = {d[2:0], 1'b1};
        end else if (b == CHAR_UP_F) begin
            c.op   = OP_MOTION;
            c.code = CODE_CLOSE;
        end else if (b == CHAR_LO_F) begin
            c.op   = OP_MOTION;
            c.code = CODE_OPEN;
        end else if (b == CHAR_UP_G) begin
            c.op = OP_TOGGLE;
        end else if (b == CHAR_LO_G) begin
            c.op = OP_PLAY;
        end
        return c;
    endfunction

    // Turns an entry code into an action; grip_in is the level before it.
    function automatic action_t perform_code(input logic [CODE_W-1:0] code,
                                             input logic grip_in);
        action_t a;
        a.kind    = KIND_NONE;
        a.joint   = 3'd0;
        a.reverse = 1'b0;
        a.grip    = grip_in;
        if (code < CODE_CLOSE) begin
            a.kind    = KIND_PULSE;
            a.joint   = code[3:1];
            a.reverse = code[0];
        end else if (code == CODE_CLOSE) begin
            a.kind = KIND_GRIP;
            a.grip = 1'b1;
        end else if (code == CODE_OPEN) begin
            a.kind = KIND_GRIP;
            a.grip = 1'b0;
        end
        return a;
    endfunction

endpackage

// ===== design/teach_record_playback_commander.sv =====
// Teach, record and playback commander for a five-joint arm with a gripper.
// Each input beat carries one received command character. 'A' to 'E' pulse
// joints 0 to 4 forward and 'a' to 'e' pulse them in reverse; 'F' closes and
// 'f' opens the gripper. While teach mode is on, each of these motion commands
// is also appended to a 32-entry record store, and once the store is full
// further commands are still carried out but are flagged as dropped. 'G'
// toggles teach mode and empties the store when teach mode is switched on.
// 'g' replays the stored commands in order, one output beat per entry with the
// playback flag set and tlast on the final one, and then empties the store;
// with nothing stored it gives a single no-action beat. Any other character
// gives one no-action beat. A front stage decodes characters into a two-entry
// command queue, so up to two commands are taken while a replay is still
// running. A single-beat command is decoded into the queue register and then
// loaded into the output register. During a replay each entry goes through
// the record store's registered read port before it is loaded into the output
// register. A stalled output holds the back end, and the queue then fills and
// deasserts s_tready. After reset the store needs no clearing; only entries
// written since the last clear are ever replayed.
module teach_record_playback_commander (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [1:0] action_kind, [4:2] joint, [5] reverse,
                                   // [6] gripper_closed, [7] teach_active,
                                   // [8] record_dropped, [15:9] zero
    output logic        m_tuser,   // [0] from_playback
    output logic        m_tlast    // last
);
    logic                   cmd_valid;
    trpc_pkg::cmd_t         cmd;
    logic                   cmd_pop;
    trpc_pkg::result_t      res;
    trpc_pkg::back_status_t status;

    // Front end: takes characters and classifies them into queued commands.
    trpc_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop)
    );

    // Back end: holds teach mode, gripper level and the record store, and
    // drives the output register.
    trpc_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop),
        .m_valid   (m_tvalid),
        .m_ready   (m_tready),
        .m_res     (res),
        .status    (status)
    );

    assign m_tdata = {7'd0, res.dropped, res.teach, res.act.grip, res.act.reverse,
                      res.act.joint, res.act.kind};
    assign m_tuser = res.playback;
    assign m_tlast = res.last;

    // The fill level of the record store never passes its depth.
    assert property (@(posedge aclk) disable iff (!aresetn)
        status.record_count <= trpc_pkg::REC_CW'(trpc_pkg::RECORD_DEPTH))
        else $error("record count beyond store depth");

    // A replay is only running while there are entries left to replay.
    assert property (@(posedge aclk) disable iff (!aresetn)
        status.playing |-> (status.record_count != '0))
        else $error("replay running with an empty store");

    // Only a replay produces more than one beat for one command.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tlast) |-> m_tuser)
        else $error("non-final beat outside a replay");

    // A dropped record belongs to a live motion command in teach mode.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[8]) |-> (m_tdata[7] && !m_tuser && m_tdata[1:0] != 2'd0))
        else $error("drop flag on a beat that cannot be recorded");

    // Replayed entries always carry an action.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (m_tdata[1:0] != 2'd0))
        else $error("replayed beat without an action");

endmodule

// ===== design/trpc_ram.sv =====
module trpc_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 32
) (
    input  logic                                         aclk,
    input  logic                                         we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                             wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                             rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/trpc_front.sv =====
module trpc_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [7:0]          s_tdata,
    output logic                cmd_valid,
    output trpc_pkg::cmd_t      cmd,
    input  logic                cmd_pop
);
    trpc_pkg::cmd_t                 q_reg [trpc_pkg::QUEUE_DEPTH];
    trpc_pkg::cmd_t                 q_next [trpc_pkg::QUEUE_DEPTH];
    logic [trpc_pkg::Q_AW-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [trpc_pkg::Q_AW-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [trpc_pkg::Q_CW-1:0]      fill_reg, fill_next;
    logic                           push;
    logic                           pop;

    assign s_tready  = (fill_reg != trpc_pkg::Q_CW'(trpc_pkg::QUEUE_DEPTH));
    assign cmd_valid = (fill_reg != '0);
    assign cmd       = q_reg[rd_ptr_reg];
    assign push      = s_tvalid && s_tready;
    assign pop       = cmd_pop && cmd_valid;

    always_comb begin
        q_next      = q_reg;
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push) begin
            q_next[wr_ptr_reg] = trpc_pkg::decode_cmd(s_tdata);
            if (wr_ptr_reg == trpc_pkg::Q_AW'(trpc_pkg::QUEUE_DEPTH - 1)) begin
                wr_ptr_next = '0;
            end else begin
                wr_ptr_next = wr_ptr_reg + 1'b1;
            end
        end
        if (pop) begin
            if (rd_ptr_reg == trpc_pkg::Q_AW'(trpc_pkg::QUEUE_DEPTH - 1)) begin
                rd_ptr_next = '0;
            end else begin
                rd_ptr_next = rd_ptr_reg + 1'b1;
            end
        end
        if (push && !pop) begin
            fill_next = fill_reg + 1'b1;
        end else if (pop && !push) begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        q_reg <= q_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

endmodule

// ===== design/trpc_back.sv =====
module trpc_back (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    cmd_valid,
    input  trpc_pkg::cmd_t          cmd,
    output logic                    cmd_pop,
    output logic                    m_valid,
    input  logic                    m_ready,
    output trpc_pkg::result_t       m_res,
    output trpc_pkg::back_status_t  status
);
    typedef enum logic [2:0] {
        ST_IDLE      = 3'b001,
        ST_PLAY_RD   = 3'b010,
        ST_PLAY_EMIT = 3'b100
    } back_state_t;

    back_state_t                        state_reg, state_next;
    logic                               teach_reg, teach_next;
    logic                               grip_reg, grip_next;
    logic [trpc_pkg::REC_CW-1:0]        count_reg, count_next;
    logic [trpc_pkg::REC_AW-1:0]        idx_reg, idx_next;
    logic                               out_valid_reg, out_valid_next;
    trpc_pkg::result_t                  out_res_reg, out_res_next;

    logic                               out_free;
    logic                               ram_we;
    logic [trpc_pkg::CODE_W-1:0]        ram_rdata;
    trpc_pkg::action_t                  act;
    logic                               is_last;

    trpc_ram #(
        .WIDTH (trpc_pkg::CODE_W),
        .DEPTH (trpc_pkg::RECORD_DEPTH)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (count_reg[trpc_pkg::REC_AW-1:0]),
        .wdata (cmd.code),
        .raddr (idx_reg),
        .rdata (ram_rdata)
    );

    assign out_free = !out_valid_reg || m_ready;
    assign is_last  = ((trpc_pkg::REC_CW'(idx_reg) + trpc_pkg::REC_CW'(1)) == count_reg);

    always_comb begin
        state_next     = state_reg;
        teach_next     = teach_reg;
        grip_next      = grip_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        out_res_next   = out_res_reg;
        out_valid_next = out_valid_reg && !m_ready;
        cmd_pop        = 1'b0;
        ram_we         = 1'b0;
        act            = trpc_pkg::perform_code(trpc_pkg::CODE_NONE, grip_reg);

        unique case (state_reg)
            ST_IDLE: begin
                if (cmd_valid && out_free) begin
                    cmd_pop               = 1'b1;
                    out_res_next.dropped  = 1'b0;
                    out_res_next.playback = 1'b0;
                    out_res_next.last     = 1'b1;
                    out_res_next.teach    = teach_reg;
                    out_res_next.act      = act;
                    unique case (cmd.op)
                        trpc_pkg::OP_MOTION: begin
                            act = trpc_pkg::perform_code(cmd.code, grip_reg);
                            grip_next = act.grip;
                            out_res_next.act = act;
                            if (teach_reg) begin
                                if (count_reg < trpc_pkg::REC_CW'(trpc_pkg::RECORD_DEPTH)) begin
                                    ram_we     = 1'b1;
                                    count_next = count_reg + 1'b1;
                                end else begin
                                    out_res_next.dropped = 1'b1;
                                end
                            end
                            out_valid_next = 1'b1;
                        end
                        trpc_pkg::OP_TOGGLE: begin
                            teach_next = !teach_reg;
                            if (!teach_reg) begin
                                count_next = '0;
                            end
                            out_res_next.teach = !teach_reg;
                            out_valid_next     = 1'b1;
                        end
                        trpc_pkg::OP_PLAY: begin
                            if (count_reg == '0) begin
                                out_valid_next = 1'b1;
                            end else begin
                                idx_next   = '0;
                                state_next = ST_PLAY_RD;
                            end
                        end
                        default: begin
                            out_valid_next = 1'b1;
                        end
                    endcase
                end
            end
            ST_PLAY_RD: begin
                // The store's read port answers on the next cycle.
                state_next = ST_PLAY_EMIT;
            end
            ST_PLAY_EMIT: begin
                if (out_free) begin
                    act = trpc_pkg::perform_code(ram_rdata, grip_reg);
                    grip_next             = act.grip;
                    out_res_next.act      = act;
                    out_res_next.teach    = teach_reg;
                    out_res_next.dropped  = 1'b0;
                    out_res_next.playback = 1'b1;
                    out_res_next.last     = is_last;
                    out_valid_next        = 1'b1;
                    if (is_last) begin
                        count_next = '0;
                        state_next = ST_IDLE;
                    end else begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = ST_PLAY_RD;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        out_res_reg <= out_res_next;
        idx_reg     <= idx_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            teach_reg     <= 1'b0;
            grip_reg      <= 1'b0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            teach_reg     <= teach_next;
            grip_reg      <= grip_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_valid             = out_valid_reg;
    assign m_res               = out_res_reg;
    assign status.record_count = count_reg;
    assign status.playing      = (state_reg != ST_IDLE);

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 100ps

// Stream-level check of the teach, record and playback commander. Command
// characters go in one beat at a time; every output beat is compared with the
// action that a local model of the commander predicts for it.
module testbench;
    import trpc_pkg::*;

    // One predicted output beat, with the fields kept apart for clear reports.
    typedef struct {
        kind_t      kind;
        logic [2:0] joint;
        logic       rev;
        logic       grip;
        logic       teach;
        logic       dropped;
        logic       playback;
        logic       last;
    } action_beat_t;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int ITEM_GOAL   = 500;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;   // [7:0] rx_byte
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;            // [1:0] action_kind, [4:2] joint, [5] reverse,
                                     // [6] gripper_closed, [7] teach_active,
                                     // [8] record_dropped, [15:9] zero
    logic        m_tuser;            // [0] from_playback
    logic        m_tlast;            // last

    teach_record_playback_commander dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Characters waiting to be sent, and actions waiting to come out.
    logic [7:0]   pending_chars[$];
    action_beat_t expected_actions[$];

    // Local copy of the commander's state, advanced once per accepted beat.
    logic       teach_q;
    logic       grip_q;
    int         rec_count;
    logic [3:0] rec_store[RECORD_DEPTH];

    // Bookkeeping for the summary and the verdict.
    int errors;
    int chars_sent;
    int beats_checked;
    int replayed_beats;
    int dropped_cmds;
    int full_replays;

    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH: %s", $realtime, msg);
        errors++;
    endtask

    // Carries out one entry code, updates the gripper level and queues the beat
    // that the commander should send for it.
    task automatic queue_action(input logic [3:0] code, input logic dropped,
                                input logic playback, input logic last);
        action_beat_t a;
        a.kind  = KIND_NONE;
        a.joint = 3'd0;
        a.rev   = 1'b0;
        if (code < CODE_CLOSE) begin
            a.kind  = KIND_PULSE;
            a.joint = code[3:1];
            a.rev   = code[0];
        end else if (code == CODE_CLOSE) begin
            a.kind = KIND_GRIP;
            grip_q = 1'b1;
        end else if (code == CODE_OPEN) begin
            a.kind = KIND_GRIP;
            grip_q = 1'b0;
        end
        a.grip     = grip_q;
        a.teach    = teach_q;
        a.dropped  = dropped;
        a.playback = playback;
        a.last     = last;
        expected_actions.push_back(a);
    endtask

    // Predicts every beat that one accepted character causes.
    task automatic apply_command(input logic [7:0] ch);
        logic [3:0] code;
        logic       dropped;
        code = CODE_NONE;
        if (ch >= CHAR_UP_A && ch <= CHAR_UP_E)
            code = 4'(2 * (ch - CHAR_UP_A));
        else if (ch >= CHAR_LO_A && ch <= CHAR_LO_E)
            code = 4'(2 * (ch - CHAR_LO_A) + 1);
        else if (ch == CHAR_UP_F)
            code = CODE_CLOSE;
        else if (ch == CHAR_LO_F)
            code = CODE_OPEN;

        if (code != CODE_NONE) begin
            // Motion commands are stored while teaching, unless the store is full.
            dropped = 1'b0;
            if (teach_q) begin
                if (rec_count < RECORD_DEPTH) begin
                    rec_store[rec_count] = code;
                    rec_count++;
                end else begin
                    dropped = 1'b1;
                    dropped_cmds++;
                end
            end
            queue_action(code, dropped, 1'b0, 1'b1);
        end else if (ch == CHAR_UP_G) begin
            // Entering teach mode starts a fresh recording; leaving keeps it.
            if (teach_q) begin
                teach_q = 1'b0;
            end else begin
                teach_q   = 1'b1;
                rec_count = 0;
            end
            queue_action(CODE_NONE, 1'b0, 1'b0, 1'b1);
        end else if (ch == CHAR_LO_G && rec_count > 0) begin
            // Replay does not record again and leaves teach mode alone.
            if (rec_count == RECORD_DEPTH)
                full_replays++;
            for (int k = 0; k < rec_count; k++)
                queue_action(rec_store[k], 1'b0, 1'b1, k == rec_count - 1);
            replayed_beats += rec_count;
            rec_count = 0;
        end else begin
            // Empty replay and any other character give a single idle beat.
            queue_action(CODE_NONE, 1'b0, 1'b0, 1'b1);
        end
    endtask

    // Driver: presents queued characters, holds each until it is taken, and
    // inserts random idle gaps between beats, except during no-gap bursts.
    int in_gap;
    bit in_burst;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= 8'h00;
            in_gap   = 0;
            in_burst = 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                apply_command(s_tdata);
                chars_sent++;
            end
            if (!(s_tvalid && !s_tready)) begin
                if (in_gap > 0) begin
                    in_gap--;
                    s_tvalid <= 1'b0;
                end else if (pending_chars.size() > 0) begin
                    s_tdata  <= pending_chars.pop_front();
                    s_tvalid <= 1'b1;
                    if ($urandom_range(0, 15) == 0)
                        in_burst = !in_burst;
                    in_gap = in_burst ? 0 : $urandom_range(0, 4);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: takes output beats, checks them against the oldest prediction,
    // and may stall the output after each beat outside bursts.
    int out_stall;
    bit out_burst;

    always @(posedge aclk) begin
        action_beat_t exp_a;
        int           n;
        if (!aresetn) begin
            m_tready  <= 1'b0;
            out_stall = 0;
            out_burst = 1'b0;
        end else if (m_tvalid && m_tready) begin
            beats_checked++;
            if (expected_actions.size() == 0) begin
                report_mismatch($sformatf("unexpected beat tdata=%h tuser=%b tlast=%b",
                                          m_tdata, m_tuser, m_tlast));
            end else begin
                exp_a = expected_actions.pop_front();
                if (m_tdata[1:0] !== exp_a.kind)
                    report_mismatch($sformatf("action_kind %0d, want %0d",
                                              m_tdata[1:0], exp_a.kind));
                if (m_tdata[4:2] !== exp_a.joint)
                    report_mismatch($sformatf("joint %0d, want %0d",
                                              m_tdata[4:2], exp_a.joint));
                if (m_tdata[5] !== exp_a.rev)
                    report_mismatch($sformatf("reverse %b, want %b", m_tdata[5], exp_a.rev));
                if (m_tdata[6] !== exp_a.grip)
                    report_mismatch($sformatf("gripper_closed %b, want %b",
                                              m_tdata[6], exp_a.grip));
                if (m_tdata[7] !== exp_a.teach)
                    report_mismatch($sformatf("teach_active %b, want %b",
                                              m_tdata[7], exp_a.teach));
                if (m_tdata[8] !== exp_a.dropped)
                    report_mismatch($sformatf("record_dropped %b, want %b",
                                              m_tdata[8], exp_a.dropped));
                if (m_tdata[15:9] !== 7'd0)
                    report_mismatch($sformatf("tdata padding %h, want 0", m_tdata[15:9]));
                if (m_tuser !== exp_a.playback)
                    report_mismatch($sformatf("from_playback %b, want %b",
                                              m_tuser, exp_a.playback));
                if (m_tlast !== exp_a.last)
                    report_mismatch($sformatf("tlast %b, want %b", m_tlast, exp_a.last));
            end
            if ($urandom_range(0, 15) == 0)
                out_burst = !out_burst;
            n = out_burst ? 0 : $urandom_range(0, 4);
            out_stall = n;
            m_tready <= (n == 0);
        end else if (!m_tready) begin
            if (out_stall <= 1)
                m_tready <= 1'b1;
            if (out_stall > 0)
                out_stall--;
        end
    end

    // The whole run, however slow, stays far below this many cycles.
    int cycle_count;

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d beats still expected",
                     cycle_count, expected_actions.size());
            $display("testbench NOT OK");
            $finish;
        end
    end

    // Stimulus generation keeps its own idea of teach mode so that it can
    // build well-formed teach, record and replay sequences.
    bit gen_teach;

    task automatic send_char(input logic [7:0] ch);
        pending_chars.push_back(ch);
        if (ch == CHAR_UP_G)
            gen_teach = !gen_teach;
    endtask

    function automatic logic [7:0] random_motion();
        int idx;
        idx = $urandom_range(0, 11);
        if (idx < 5)
            return CHAR_UP_A + 8'(idx);
        else if (idx < 10)
            return CHAR_LO_A + 8'(idx - 5);
        else if (idx == 10)
            return CHAR_UP_F;
        return CHAR_LO_F;
    endfunction

    initial begin
        int moves;

        teach_q        = 1'b0;
        grip_q         = 1'b0;
        rec_count      = 0;
        errors         = 0;
        chars_sent     = 0;
        beats_checked  = 0;
        replayed_beats = 0;
        dropped_cmds   = 0;
        full_replays   = 0;
        cycle_count    = 0;
        gen_teach      = 1'b0;

        // Directed part: byte extremes and neighbors of the command letters,
        // an empty replay, every motion letter kind, replay while teaching,
        // a replay right after another, and a replay after teach mode is left.
        send_char(8'h00);
        send_char(8'hFF);
        send_char(CHAR_LO_G);
        send_char(CHAR_UP_A);
        send_char(CHAR_LO_E);
        send_char(CHAR_UP_F);
        send_char(CHAR_LO_F);
        send_char(CHAR_UP_G);
        send_char(CHAR_UP_E);
        send_char(CHAR_LO_A);
        send_char(CHAR_UP_F);
        send_char(8'h40);
        send_char(CHAR_LO_F);
        send_char(CHAR_LO_G);
        send_char(CHAR_LO_G);
        send_char(CHAR_UP_G);
        send_char(CHAR_LO_A + 8'd1);
        send_char(CHAR_UP_G);
        send_char(CHAR_UP_A + 8'd2);
        send_char(CHAR_LO_A + 8'd3);
        send_char(CHAR_UP_G);
        send_char(8'h60);
        send_char(CHAR_LO_G);
        send_char(8'h48);
        send_char(8'h68);

        // Random part: mostly teach sessions with random moves, some long
        // enough to fill the store and overflow it, then a replay; the rest
        // is arbitrary bytes.
        while (pending_chars.size() < ITEM_GOAL) begin
            if ($urandom_range(0, 6) == 0) begin
                repeat ($urandom_range(1, 3))
                    send_char(8'($urandom_range(0, 255)));
            end else begin
                if (!gen_teach)
                    send_char(CHAR_UP_G);
                if ($urandom_range(0, 5) == 0)
                    moves = $urandom_range(RECORD_DEPTH - 2, RECORD_DEPTH + 8);
                else
                    moves = $urandom_range(0, 12);
                repeat (moves) begin
                    if ($urandom_range(0, 9) == 0)
                        send_char(8'($urandom_range(0, 255)));
                    send_char(random_motion());
                end
                if ($urandom_range(0, 1) == 0) begin
                    send_char(CHAR_UP_G);
                    if ($urandom_range(0, 2) == 0)
                        send_char(random_motion());
                end
                send_char(CHAR_LO_G);
                if ($urandom_range(0, 4) == 0)
                    send_char(CHAR_LO_G);
            end
        end

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        while (pending_chars.size() != 0 || s_tvalid || expected_actions.size() != 0)
            @(posedge aclk);
        // A little extra time to catch any beat that should not be there.
        repeat (100) @(posedge aclk);

        $display("Sent %0d command beats and checked %0d action beats.",
                 chars_sent, beats_checked);
        $display("Replayed %0d entries (%0d full-store replays), %0d commands dropped.",
                 replayed_beats, full_replays, dropped_cmds);
        if (errors == 0) begin
            $display("testbench OK");
        end else begin
            $display("%0d mismatches", errors);
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule
